// File: rtl/core/tnns_pkg.sv
package tnns_pkg;

    localparam int COORD_BITS    = 12;
    localparam int GROUP_BITS    = 4;
    localparam int DELTA_BITS    = 13;
    localparam int DIST_BITS     = 24;
    localparam int MODE_BITS     = 2;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 12;

    localparam logic [COORD_BITS-1:0] WORLD_SIZE_RESET = 12'd1024;
    localparam logic [GROUP_BITS-1:0] FOOD_GROUP_RESET = 4'd15;

    localparam logic [CFG_IDX_BITS-1:0] CFG_WORLD_SIZE = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FOOD_GROUP = 1'b1;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_SAME      = 2'd0,
        MODE_SAME_SKIP = 2'd1,
        MODE_OTHER     = 2'd2,
        MODE_NONE      = 2'd3
    } search_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [GROUP_BITS-1:0] grp;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic write_item;
        logic load_query;
        logic scan;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;
        logic pipe_busy;
    } stat_t;

endpackage

// File: rtl/core/tnns_ctrl.sv
module tnns_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             action,
    input  tnns_pkg::stat_t  stat,
    output tnns_pkg::cmd_t   cmd,
    output logic             busy,
    output logic             done
);

    tnns_pkg::state_t state_reg;
    tnns_pkg::state_t state_next;
    logic             accept;

    assign accept = start && (state_reg == tnns_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tnns_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tnns_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (action == tnns_pkg::ACT_QUERY)
                    begin
                        state_next = tnns_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = tnns_pkg::ST_REPORT;
                    end
                end
            end
            tnns_pkg::ST_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = tnns_pkg::ST_DRAIN;
                end
            end
            tnns_pkg::ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = tnns_pkg::ST_REPORT;
                end
            end
            tnns_pkg::ST_REPORT:
            begin
                state_next = tnns_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tnns_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.write_item = accept && (action == tnns_pkg::ACT_WRITE);
        cmd.load_query = accept && (action == tnns_pkg::ACT_QUERY);
        cmd.scan       = (state_reg == tnns_pkg::ST_SCAN);
        busy           = (state_reg != tnns_pkg::ST_IDLE);
        done           = (state_reg == tnns_pkg::ST_REPORT);
    end

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_write_reports: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_item |=> done)
        else $error("write item not reported in the next cycle");

    a_scan_to_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan && stat.scan_last) |=> (state_reg == tnns_pkg::ST_DRAIN))
        else $error("scan did not end after the last entry");

endmodule

// File: rtl/core/tnns_datapath.sv
module tnns_datapath
#(
    parameter int ENTRY_COUNT = 64,
    parameter int IDX_W       = 6
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  tnns_pkg::cmd_t                         cmd,
    output tnns_pkg::stat_t                        stat,
    input  logic                                   cfg_we,
    input  logic [tnns_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [tnns_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic [IDX_W-1:0]                       entry_index,
    input  logic [tnns_pkg::COORD_BITS-1:0]        pos_x,
    input  logic [tnns_pkg::COORD_BITS-1:0]        pos_y,
    input  logic [tnns_pkg::GROUP_BITS-1:0]        group,
    input  logic                                   alive,
    input  logic [tnns_pkg::MODE_BITS-1:0]         search_mode,
    output logic                                   found,
    output logic [IDX_W-1:0]                       nearest_index,
    output logic signed [tnns_pkg::DELTA_BITS-1:0] delta_x,
    output logic signed [tnns_pkg::DELTA_BITS-1:0] delta_y,
    output logic [tnns_pkg::DIST_BITS-1:0]         dist_sq
);

    localparam int CW = tnns_pkg::COORD_BITS;
    localparam int GW = tnns_pkg::GROUP_BITS;
    localparam int DW = tnns_pkg::DELTA_BITS;
    localparam int SW = tnns_pkg::DIST_BITS;

    // wrapped offset on one axis; result always fits in DW bits
    function automatic logic signed [DW-1:0] wrap_axis(
        input logic [CW-1:0] e,
        input logic [CW-1:0] q,
        input logic [CW-1:0] side
    );
        logic signed [CW+1:0] d;
        logic [CW:0]          mag;
        logic signed [CW+1:0] rest;
        logic signed [CW+1:0] res;
        d    = $signed({2'b00, e}) - $signed({2'b00, q});
        mag  = d[CW+1] ? (CW+1)'(-d) : (CW+1)'(d);
        rest = $signed({2'b00, side}) - $signed({1'b0, mag});
        res  = d;
        if (mag > {2'b00, side[CW-1:1]})
        begin
            res = d[CW+1] ? rest : -rest;
        end
        return res[DW-1:0];
    endfunction

    // configuration
    logic [CW-1:0] side_reg;
    logic [GW-1:0] food_group_reg;
    logic [SW-1:0] side_sq;

    // table
    tnns_pkg::entry_t        mem [ENTRY_COUNT];
    logic [ENTRY_COUNT-1:0]  alive_reg;
    logic                    slot_ok;

    // query
    logic [CW-1:0]           q_x_reg;
    logic [CW-1:0]           q_y_reg;
    logic [GW-1:0]           q_grp_reg;
    logic [tnns_pkg::MODE_BITS-1:0] q_mode_reg;
    logic [IDX_W-1:0]        scan_cnt_reg;

    // pipeline: read, wrap, square, compare
    logic                    v1_reg;
    tnns_pkg::entry_t        rd_reg;
    logic                    alive1_reg;
    logic [IDX_W-1:0]        idx1_reg;
    logic                    match1;

    logic                    v2_reg;
    logic signed [DW-1:0]    dx2_reg;
    logic signed [DW-1:0]    dy2_reg;
    logic [IDX_W-1:0]        idx2_reg;

    logic                    v3_reg;
    logic signed [2*DW-1:0]  prod_x;
    logic signed [2*DW-1:0]  prod_y;
    logic [SW-1:0]           sqx3_reg;
    logic [SW-1:0]           sqy3_reg;
    logic signed [DW-1:0]    dx3_reg;
    logic signed [DW-1:0]    dy3_reg;
    logic [IDX_W-1:0]        idx3_reg;
    logic [SW:0]             sum3;

    // best so far / result
    logic                    best_found_reg;
    logic [IDX_W-1:0]        best_idx_reg;
    logic signed [DW-1:0]    best_dx_reg;
    logic signed [DW-1:0]    best_dy_reg;
    logic [SW-1:0]           best_dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg       <= tnns_pkg::WORLD_SIZE_RESET;
            food_group_reg <= tnns_pkg::FOOD_GROUP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tnns_pkg::CFG_WORLD_SIZE: side_reg <= cfg_data[CW-1:0];
                tnns_pkg::CFG_FOOD_GROUP: food_group_reg <= cfg_data[GW-1:0];
                default: ;
            endcase
        end
    end

    assign side_sq = {{(SW-CW){1'b0}}, side_reg} * {{(SW-CW){1'b0}}, side_reg};

    assign slot_ok = ({1'b0, entry_index} < (IDX_W+1)'(ENTRY_COUNT));

    always_ff @(posedge clk)
    begin
        if (cmd.write_item && slot_ok)
        begin
            mem[entry_index] <= '{x: pos_x, y: pos_y, grp: group};
        end
        rd_reg <= mem[scan_cnt_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alive_reg <= '0;
        end
        else if (cmd.write_item && slot_ok)
        begin
            alive_reg[entry_index] <= alive;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
        end
        else
        begin
            if (cmd.load_query)
            begin
                scan_cnt_reg <= '0;
            end
            else if (cmd.scan)
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
            v1_reg <= cmd.scan;
            v2_reg <= v1_reg && alive1_reg && match1;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            q_x_reg    <= pos_x;
            q_y_reg    <= pos_y;
            q_grp_reg  <= group;
            q_mode_reg <= search_mode;
        end
        alive1_reg <= alive_reg[scan_cnt_reg];
        idx1_reg   <= scan_cnt_reg;
    end

    // candidate filter on the entry just read
    always_comb
    begin
        case (tnns_pkg::search_mode_t'(q_mode_reg))
            tnns_pkg::MODE_SAME:
                match1 = (rd_reg.grp == q_grp_reg);
            tnns_pkg::MODE_SAME_SKIP:
                match1 = (rd_reg.grp == q_grp_reg)
                      && !((rd_reg.x == q_x_reg) && (rd_reg.y == q_y_reg));
            tnns_pkg::MODE_OTHER:
                match1 = (rd_reg.grp != q_grp_reg) && (rd_reg.grp != food_group_reg);
            tnns_pkg::MODE_NONE:
                match1 = 1'b0;
            default:
                match1 = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        dx2_reg  <= wrap_axis(rd_reg.x, q_x_reg, side_reg);
        dy2_reg  <= wrap_axis(rd_reg.y, q_y_reg, side_reg);
        idx2_reg <= idx1_reg;
    end

    assign prod_x = dx2_reg * dx2_reg;
    assign prod_y = dy2_reg * dy2_reg;

    always_ff @(posedge clk)
    begin
        sqx3_reg <= prod_x[SW-1:0];
        sqy3_reg <= prod_y[SW-1:0];
        dx3_reg  <= dx2_reg;
        dy3_reg  <= dy2_reg;
        idx3_reg <= idx2_reg;
    end

    assign sum3 = {1'b0, sqx3_reg} + {1'b0, sqy3_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_found_reg <= 1'b0;
        end
        else if (cmd.write_item || cmd.load_query)
        begin
            best_found_reg <= 1'b0;
        end
        else if (v3_reg && (sum3 < {1'b0, best_dist_reg}))
        begin
            best_found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_item || cmd.load_query)
        begin
            best_idx_reg <= '0;
            best_dx_reg  <= '0;
            best_dy_reg  <= '0;
            // a write reports zero distance, a query starts at world size squared
            best_dist_reg <= cmd.load_query ? side_sq : '0;
        end
        else if (v3_reg && (sum3 < {1'b0, best_dist_reg}))
        begin
            best_idx_reg  <= idx3_reg;
            best_dx_reg   <= dx3_reg;
            best_dy_reg   <= dy3_reg;
            best_dist_reg <= sum3[SW-1:0];
        end
    end

    assign stat.scan_last = (scan_cnt_reg == IDX_W'(ENTRY_COUNT - 1));
    assign stat.pipe_busy = v1_reg || v2_reg;

    assign found         = best_found_reg;
    assign nearest_index = best_idx_reg;
    assign delta_x       = best_dx_reg;
    assign delta_y       = best_dy_reg;
    assign dist_sq       = best_dist_reg;

    a_query_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_query |=> !best_found_reg)
        else $error("best entry not cleared at query start");

    a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> $past(v1_reg, 2))
        else $error("compare stage valid without a read two cycles earlier");

endmodule

// File: rtl/core/toroidal_nearest_neighbour_search.sv
// Nearest-neighbour search over a table of points on a square torus.
// Items enter on start with action, entry_index, pos_x, pos_y, group,
// alive and search_mode; an item is taken at a clock edge where start is
// high and busy is low. One result item follows every input item: done
// is high for exactly one cycle with found, nearest_index, delta_x,
// delta_y and dist_sq valid in that cycle. The receiver cannot stall.
// A write item loads one table slot; its result (all zero) shows in the
// cycle after it is taken.
// A query scans the table one slot per cycle from the table memory,
// through a four-stage read/wrap/square/compare pipeline: done is high
// once the last slot has been read and the pipeline has drained, and the
// next item can be taken only after that done cycle.
// Configuration (world side at index 0, food_group at index 1) is written
// through cfg_we/cfg_index/cfg_data; the user must write it only while
// the block is idle, as the block does not enforce this.
// Reset clears all alive bits at once and restores world side 1024 and
// food_group 15; no clearing pass is needed.
module toroidal_nearest_neighbour_search
#(
    parameter int ENTRY_COUNT = 64
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    output logic                                   done,
    input  logic                                   cfg_we,
    input  logic [tnns_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [tnns_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                                   action,
    input  logic [$clog2(ENTRY_COUNT)-1:0]         entry_index,
    input  logic [tnns_pkg::COORD_BITS-1:0]        pos_x,
    input  logic [tnns_pkg::COORD_BITS-1:0]        pos_y,
    input  logic [tnns_pkg::GROUP_BITS-1:0]        group,
    input  logic                                   alive,
    input  logic [tnns_pkg::MODE_BITS-1:0]         search_mode,
    output logic                                   found,
    output logic [$clog2(ENTRY_COUNT)-1:0]         nearest_index,
    output logic signed [tnns_pkg::DELTA_BITS-1:0] delta_x,
    output logic signed [tnns_pkg::DELTA_BITS-1:0] delta_y,
    output logic [tnns_pkg::DIST_BITS-1:0]         dist_sq
);

    localparam int IDX_W = $clog2(ENTRY_COUNT);

    tnns_pkg::cmd_t  cmd;
    tnns_pkg::stat_t stat;

    tnns_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    tnns_datapath
    #(
        .ENTRY_COUNT (ENTRY_COUNT),
        .IDX_W       (IDX_W)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .entry_index   (entry_index),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .group         (group),
        .alive         (alive),
        .search_mode   (search_mode),
        .found         (found),
        .nearest_index (nearest_index),
        .delta_x       (delta_x),
        .delta_y       (delta_y),
        .dist_sq       (dist_sq)
    );

endmodule
